FILE: design/pulse_width_bit_sender_assert.svh
// Assertion macros shared by the pulse-width sender modules.
`ifndef PULSE_WIDTH_BIT_SENDER_ASSERT_SVH
`define PULSE_WIDTH_BIT_SENDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PWBS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pwbs assertion failed");

// Next-cycle implication, checked outside reset.
`define PWBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pwbs assertion failed");

`endif

FILE: design/pwbs_pkg.sv
package pwbs_pkg;

  // Default word length of a byte load.
  localparam int BITS_PER_WORD_DEF = 8;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LONG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP   = 3'd4;

  // Register reset values.
  localparam logic [CFG_W-1:0] LONG_RST  = 8'd40;
  localparam logic [CFG_W-1:0] SHORT_RST = 8'd10;
  localparam logic [CFG_W-1:0] LEAD_RST  = 8'd200;
  localparam logic [CFG_W-1:0] PULSE_RST = 8'd50;
  localparam logic [CFG_W-1:0] GAP_RST   = 8'd20;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_MARK = 2'd2;

  // Sender modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_BYTE = 2'd1;
  localparam logic [1:0] MODE_MARK = 2'd2;

  // Marker steps.
  localparam logic [2:0] MARK_LEAD   = 3'd0;
  localparam logic [2:0] MARK_PULSE1 = 3'd1;
  localparam logic [2:0] MARK_GAP1   = 3'd2;
  localparam logic [2:0] MARK_PULSE2 = 3'd3;
  localparam logic [2:0] MARK_GAP2   = 3'd4;
  localparam logic [2:0] MARK_TAIL   = 3'd5;

  // Phase lengths from the configuration registers.
  typedef struct packed {
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] marker_lead_ticks;
    logic [CFG_W-1:0] marker_pulse_ticks;
    logic [CFG_W-1:0] marker_gap_ticks;
  } timing_t;

  // One result item.
  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic done_res;
    logic rejected;
  } result_t;

endpackage

FILE: design/pwbs_core.sv
`include "pulse_width_bit_sender_assert.svh"

module pwbs_core #(
  parameter int BITS_PER_WORD = pwbs_pkg::BITS_PER_WORD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [1:0]        kind,
  input  logic [7:0]        data_byte,
  input  pwbs_pkg::timing_t timing,
  output pwbs_pkg::result_t result
);

  localparam int IDX_W = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
  localparam logic [IDX_W-1:0] LAST_BIT = IDX_W'(BITS_PER_WORD - 1);

  logic [1:0]               mode, mode_next;
  logic [BITS_PER_WORD-1:0] shift_bits, shift_bits_next;
  logic [IDX_W-1:0]         bit_index, bit_index_next;
  logic                     high_phase, high_phase_next;
  logic [2:0]               marker_step, marker_step_next;
  logic [7:0]               tick_count, tick_count_next;

  logic                     cur_level;
  logic [7:0]               raw_len, phase_len, tick_inc;
  logic [BITS_PER_WORD+7:0] data_ext;
  logic                     level, done, rej;

  assign data_ext = {{BITS_PER_WORD{1'b0}}, data_byte};
  assign tick_inc = tick_count + 8'd1;

  // Level the pin holds in the current phase.
  always_comb begin
    unique case (mode)
      pwbs_pkg::MODE_BYTE: cur_level = high_phase;
      pwbs_pkg::MODE_MARK: cur_level = (marker_step == pwbs_pkg::MARK_PULSE1) ||
                                       (marker_step == pwbs_pkg::MARK_PULSE2);
      default:             cur_level = 1'b0;
    endcase
  end

  // Length of the current phase; a zero register still gives one tick.
  always_comb begin
    if (mode == pwbs_pkg::MODE_BYTE) begin
      if (high_phase == shift_bits[BITS_PER_WORD-1]) begin
        raw_len = timing.long_ticks;
      end else begin
        raw_len = timing.short_ticks;
      end
    end else if ((marker_step == pwbs_pkg::MARK_PULSE1) ||
                 (marker_step == pwbs_pkg::MARK_PULSE2)) begin
      raw_len = timing.marker_pulse_ticks;
    end else if ((marker_step == pwbs_pkg::MARK_GAP1) ||
                 (marker_step == pwbs_pkg::MARK_GAP2)) begin
      raw_len = timing.marker_gap_ticks;
    end else begin
      raw_len = timing.marker_lead_ticks;
    end
    phase_len = (raw_len == 8'd0) ? 8'd1 : raw_len;
  end

  // Next state and result for one item.
  always_comb begin
    mode_next        = mode;
    shift_bits_next  = shift_bits;
    bit_index_next   = bit_index;
    high_phase_next  = high_phase;
    marker_step_next = marker_step;
    tick_count_next  = tick_count;
    level            = cur_level;
    done             = 1'b0;
    rej              = 1'b0;
    unique case (kind)
      pwbs_pkg::KIND_TICK: begin
        if (mode != pwbs_pkg::MODE_IDLE) begin
          tick_count_next = tick_inc;
          if (tick_inc >= phase_len) begin
            tick_count_next = 8'd0;
            if (mode == pwbs_pkg::MODE_BYTE) begin
              if (high_phase) begin
                high_phase_next = 1'b0;
              end else begin
                shift_bits_next = shift_bits << 1;
                if (bit_index == LAST_BIT) begin
                  mode_next      = pwbs_pkg::MODE_IDLE;
                  bit_index_next = '0;
                  done           = 1'b1;
                end else begin
                  bit_index_next  = bit_index + IDX_W'(1);
                  high_phase_next = 1'b1;
                end
              end
            end else begin
              if (marker_step >= pwbs_pkg::MARK_TAIL) begin
                mode_next        = pwbs_pkg::MODE_IDLE;
                marker_step_next = pwbs_pkg::MARK_LEAD;
                done             = 1'b1;
              end else begin
                marker_step_next = marker_step + 3'd1;
              end
            end
          end
        end
      end
      pwbs_pkg::KIND_BYTE: begin
        if (mode != pwbs_pkg::MODE_IDLE) begin
          rej = 1'b1;
        end else begin
          mode_next       = pwbs_pkg::MODE_BYTE;
          shift_bits_next = data_ext[BITS_PER_WORD-1:0];
          bit_index_next  = '0;
          high_phase_next = 1'b1;
          tick_count_next = 8'd0;
          level           = 1'b1;
        end
      end
      pwbs_pkg::KIND_MARK: begin
        if (mode != pwbs_pkg::MODE_IDLE) begin
          rej = 1'b1;
        end else begin
          mode_next        = pwbs_pkg::MODE_MARK;
          marker_step_next = pwbs_pkg::MARK_LEAD;
          high_phase_next  = 1'b0;
          tick_count_next  = 8'd0;
          level            = 1'b0;
        end
      end
      default: begin
        level = cur_level;
      end
    endcase
  end

  assign result.pin_level = level;
  assign result.busy_res  = (mode_next != pwbs_pkg::MODE_IDLE);
  assign result.done_res  = done;
  assign result.rejected  = rej;

  // Sender state, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= pwbs_pkg::MODE_IDLE;
      shift_bits  <= '0;
      bit_index   <= '0;
      high_phase  <= 1'b0;
      marker_step <= pwbs_pkg::MARK_LEAD;
      tick_count  <= 8'd0;
    end else if (step_en) begin
      mode        <= mode_next;
      shift_bits  <= shift_bits_next;
      bit_index   <= bit_index_next;
      high_phase  <= high_phase_next;
      marker_step <= marker_step_next;
      tick_count  <= tick_count_next;
    end
  end

  // An idle sender has all its counters back at zero.
  `PWBS_ASSERT_NOW(a_idle_clear, clk, rst, mode == pwbs_pkg::MODE_IDLE,
    (tick_count == 8'd0) && (bit_index == '0) && (marker_step == pwbs_pkg::MARK_LEAD))
  // A load taken while busy changes nothing.
  `PWBS_ASSERT_NEXT(a_reject_hold, clk, rst,
    step_en && result.rejected,
    (mode == $past(mode)) && (tick_count == $past(tick_count)) &&
    (shift_bits == $past(shift_bits)))
  // A finished sequence leaves the sender idle.
  `PWBS_ASSERT_NEXT(a_done_idle, clk, rst,
    step_en && result.done_res, mode == pwbs_pkg::MODE_IDLE)

endmodule

FILE: design/pulse_width_bit_sender.sv
// Channel   Handshake               Payload
// in        in_valid / in_ready     kind, data_byte
// out       out_valid / out_ready   pin_level, busy_res, done_res, rejected
// cfg       cfg_write_en            cfg_index, cfg_data
//
// One item is taken per cycle while in_ready is high; the sender state and result
// are computed in one pass, and the result enters the output or skid register.
// A two-entry output stage (result register plus skid register) keeps in_ready
// high while one result waits; in_ready drops only when both entries are full.
// Synchronous reset clears sender state and both output entries, presets registers.
`include "pulse_width_bit_sender_assert.svh"

module pulse_width_bit_sender #(
  parameter int BITS_PER_WORD = pwbs_pkg::BITS_PER_WORD_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       data_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             pin_level,
  output logic                             busy_res,
  output logic                             done_res,
  output logic                             rejected,
  input  logic                             cfg_write_en,
  input  logic [pwbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pwbs_pkg::CFG_W-1:0]       cfg_data
);

  pwbs_pkg::timing_t timing;
  pwbs_pkg::result_t step_res, out_res, skid_res;
  logic              in_xfer, out_xfer, skid_valid;

  assign in_ready = !skid_valid;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.long_ticks         <= pwbs_pkg::LONG_RST;
      timing.short_ticks        <= pwbs_pkg::SHORT_RST;
      timing.marker_lead_ticks  <= pwbs_pkg::LEAD_RST;
      timing.marker_pulse_ticks <= pwbs_pkg::PULSE_RST;
      timing.marker_gap_ticks   <= pwbs_pkg::GAP_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        pwbs_pkg::REG_LONG:  timing.long_ticks         <= cfg_data;
        pwbs_pkg::REG_SHORT: timing.short_ticks        <= cfg_data;
        pwbs_pkg::REG_LEAD:  timing.marker_lead_ticks  <= cfg_data;
        pwbs_pkg::REG_PULSE: timing.marker_pulse_ticks <= cfg_data;
        pwbs_pkg::REG_GAP:   timing.marker_gap_ticks   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pwbs_core #(
    .BITS_PER_WORD (BITS_PER_WORD)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_en   (in_xfer),
    .kind      (kind),
    .data_byte (data_byte),
    .timing    (timing),
    .result    (step_res)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_xfer || !out_valid) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res   <= step_res;
        out_valid <= in_xfer;
      end
    end else if (in_xfer) begin
      skid_res   <= step_res;
      skid_valid <= 1'b1;
    end
  end

  assign pin_level = out_res.pin_level;
  assign busy_res  = out_res.busy_res;
  assign done_res  = out_res.done_res;
  assign rejected  = out_res.rejected;

  // The skid entry is only used behind a full output register.
  `PWBS_ASSERT_NOW(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  // A stalled result is not dropped.
  `PWBS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // A transfer into a stalled output lands in the skid entry.
  `PWBS_ASSERT_NEXT(a_skid_fill, clk, rst,
    in_xfer && out_valid && !out_ready, skid_valid)

endmodule

FILE: dv/pulse_width_bit_sender_tb.sv
`timescale 1ns / 100ps

module pulse_width_bit_sender_tb;

  localparam int WORD_BITS = pwbs_pkg::BITS_PER_WORD_DEF;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 10;

  // The kind code that the block leaves unused.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // One item waiting to be sent, with the result that it must produce.
  typedef struct {
    logic [1:0]        op;
    logic [7:0]        data;
    pwbs_pkg::result_t result;
  } tx_item_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = pwbs_pkg::KIND_TICK;
  logic [7:0] data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic pin_level;
  logic busy_res;
  logic done_res;
  logic rejected;
  logic cfg_write_en = 1'b0;
  logic [pwbs_pkg::CFG_IDX_W-1:0] cfg_index = pwbs_pkg::REG_LONG;
  logic [pwbs_pkg::CFG_W-1:0] cfg_data = '0;

  pulse_width_bit_sender dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pin_level    (pin_level),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .rejected     (rejected),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the sender: timing registers and line state.
  pwbs_pkg::timing_t      phase_cfg;
  logic [1:0]             tx_mode;
  logic [WORD_BITS-1:0]   tx_shift;
  logic [3:0]             tx_bit;
  logic                   tx_high;
  logic [2:0]             tx_step;
  logic [7:0]             tx_ticks;

  tx_item_t          tx_items_q[$];
  pwbs_pkg::result_t due_results_q[$];
  pwbs_pkg::result_t in_flight_result;
  tx_item_t          next_tx;
  pwbs_pkg::result_t want;

  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  int unsigned recv_stall;
  int          mismatches = 0;
  int          cycle_count = 0;

  function automatic void reset_sender_model();
    phase_cfg.long_ticks         = pwbs_pkg::LONG_RST;
    phase_cfg.short_ticks        = pwbs_pkg::SHORT_RST;
    phase_cfg.marker_lead_ticks  = pwbs_pkg::LEAD_RST;
    phase_cfg.marker_pulse_ticks = pwbs_pkg::PULSE_RST;
    phase_cfg.marker_gap_ticks   = pwbs_pkg::GAP_RST;
    tx_mode  = pwbs_pkg::MODE_IDLE;
    tx_shift = '0;
    tx_bit   = '0;
    tx_high  = 1'b0;
    tx_step  = pwbs_pkg::MARK_LEAD;
    tx_ticks = '0;
  endfunction

  // Level that the pin holds in the current phase.
  function automatic logic line_level();
    if (tx_mode == pwbs_pkg::MODE_BYTE) return tx_high;
    if (tx_mode == pwbs_pkg::MODE_MARK) begin
      return (tx_step == pwbs_pkg::MARK_PULSE1 || tx_step == pwbs_pkg::MARK_PULSE2);
    end
    return 1'b0;
  endfunction

  // Length of the current phase in ticks; a zero register still lasts one tick.
  function automatic int phase_ticks();
    logic [7:0] len;
    logic       one;
    one = tx_shift[WORD_BITS-1];
    if (tx_mode == pwbs_pkg::MODE_BYTE) begin
      if (tx_high) len = one ? phase_cfg.long_ticks : phase_cfg.short_ticks;
      else len = one ? phase_cfg.short_ticks : phase_cfg.long_ticks;
    end else if (tx_step == pwbs_pkg::MARK_PULSE1 || tx_step == pwbs_pkg::MARK_PULSE2) begin
      len = phase_cfg.marker_pulse_ticks;
    end else if (tx_step == pwbs_pkg::MARK_GAP1 || tx_step == pwbs_pkg::MARK_GAP2) begin
      len = phase_cfg.marker_gap_ticks;
    end else begin
      len = phase_cfg.marker_lead_ticks;
    end
    return (len == 0) ? 1 : int'(len);
  endfunction

  // Advances the shadow by one item and returns the result the block must give.
  function automatic pwbs_pkg::result_t sender_step(logic [1:0] op, logic [7:0] data);
    pwbs_pkg::result_t r;
    int                len;
    int                cnt;
    r = '0;
    if (op == pwbs_pkg::KIND_TICK) begin
      r.pin_level = line_level();
      if (tx_mode != pwbs_pkg::MODE_IDLE) begin
        len = phase_ticks();
        cnt = (int'(tx_ticks) + 1) % 256;
        if (cnt >= len) begin
          tx_ticks = '0;
          if (tx_mode == pwbs_pkg::MODE_BYTE) begin
            if (tx_high) begin
              tx_high = 1'b0;
            end else begin
              tx_shift = tx_shift << 1;
              tx_bit = tx_bit + 1'b1;
              if (tx_bit >= WORD_BITS) begin
                tx_mode = pwbs_pkg::MODE_IDLE;
                tx_bit = '0;
                r.done_res = 1'b1;
              end else begin
                tx_high = 1'b1;
              end
            end
          end else if (tx_step >= pwbs_pkg::MARK_TAIL) begin
            tx_mode = pwbs_pkg::MODE_IDLE;
            tx_step = pwbs_pkg::MARK_LEAD;
            r.done_res = 1'b1;
          end else begin
            tx_step = tx_step + 1'b1;
          end
        end else begin
          tx_ticks = cnt[7:0];
        end
      end
    end else if (op == pwbs_pkg::KIND_BYTE || op == pwbs_pkg::KIND_MARK) begin
      if (tx_mode != pwbs_pkg::MODE_IDLE) begin
        r.rejected = 1'b1;
      end else if (op == pwbs_pkg::KIND_BYTE) begin
        tx_mode  = pwbs_pkg::MODE_BYTE;
        tx_shift = WORD_BITS'(data);
        tx_bit   = '0;
        tx_high  = 1'b1;
        tx_ticks = '0;
      end else begin
        tx_mode  = pwbs_pkg::MODE_MARK;
        tx_step  = pwbs_pkg::MARK_LEAD;
        tx_high  = 1'b0;
        tx_ticks = '0;
      end
      r.pin_level = line_level();
    end else begin
      r.pin_level = line_level();
    end
    r.busy_res = (tx_mode != pwbs_pkg::MODE_IDLE);
    return r;
  endfunction

  // Idle length between transfers: mostly none or short, a few long, and
  // now and then a calm stretch with no idling at all.
  function automatic int unsigned idle_len(inout int unsigned calm_left);
    int unsigned roll;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 24);
  endfunction

  task automatic push_item(logic [1:0] op, logic [7:0] data);
    tx_item_t it;
    it.op = op;
    it.data = data;
    it.result = sender_step(op, data);
    tx_items_q.push_back(it);
  endtask

  // Ticks until the shadow sender goes idle.
  task automatic finish_sequence();
    while (tx_mode != pwbs_pkg::MODE_IDLE) begin
      push_item(pwbs_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    end
  endtask

  // Waits until every item has gone in and every result has come out.
  task automatic wait_drained();
    while (tx_items_q.size() != 0 || in_valid || due_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [pwbs_pkg::CFG_IDX_W-1:0] idx,
                           logic [pwbs_pkg::CFG_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      pwbs_pkg::REG_LONG:  phase_cfg.long_ticks = val;
      pwbs_pkg::REG_SHORT: phase_cfg.short_ticks = val;
      pwbs_pkg::REG_LEAD:  phase_cfg.marker_lead_ticks = val;
      pwbs_pkg::REG_PULSE: phase_cfg.marker_pulse_ticks = val;
      pwbs_pkg::REG_GAP:   phase_cfg.marker_gap_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(int lng, int sht, int lead, int pulse, int gap);
    wait_drained();
    write_reg(pwbs_pkg::REG_LONG, pwbs_pkg::CFG_W'(lng));
    write_reg(pwbs_pkg::REG_SHORT, pwbs_pkg::CFG_W'(sht));
    write_reg(pwbs_pkg::REG_LEAD, pwbs_pkg::CFG_W'(lead));
    write_reg(pwbs_pkg::REG_PULSE, pwbs_pkg::CFG_W'(pulse));
    write_reg(pwbs_pkg::REG_GAP, pwbs_pkg::CFG_W'(gap));
    cfg_write_en <= 1'b0;
  endtask

  // Random traffic: mostly whole sequences of ticks after a load, with loads
  // that land while busy and unused kinds mixed in as noise.
  task automatic run_random(int n);
    int count;
    int roll;
    count = 0;
    while (count < n) begin
      roll = $urandom_range(0, 99);
      if (tx_mode == pwbs_pkg::MODE_IDLE) begin
        if (roll < 55) begin
          push_item(pwbs_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
          count++;
        end else if (roll < 75) begin
          push_item(pwbs_pkg::KIND_MARK, 8'($urandom_range(0, 255)));
          count++;
        end else if (roll < 95) begin
          push_item(pwbs_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
          count++;
        end else begin
          push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
        end
      end else begin
        if (roll < 92) begin
          push_item(pwbs_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
          count++;
        end else if (roll < 95) begin
          push_item(pwbs_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
        end else if (roll < 98) begin
          push_item(pwbs_pkg::KIND_MARK, 8'($urandom_range(0, 255)));
        end else begin
          push_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
        end
      end
    end
    finish_sequence();
  endtask

  task automatic check_field(string field, logic exp_val, logic act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0b, actual %0b", field, exp_val, act_val);
      mismatches++;
    end
  endtask

  // Input side: holds each item until its transfer, then idles at random.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) due_results_q.push_back(in_flight_result);
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait <= send_wait - 1;
          in_valid <= 1'b0;
        end else if (tx_items_q.size() != 0) begin
          next_tx = tx_items_q.pop_front();
          kind <= next_tx.op;
          data_byte <= next_tx.data;
          in_flight_result <= next_tx.result;
          in_valid <= 1'b1;
          send_wait <= idle_len(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: checks each result transfer and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results_q.size() == 0) begin
          $error("result transfer with no expected result waiting");
          mismatches++;
        end else begin
          want = due_results_q.pop_front();
          check_field("pin_level", want.pin_level, pin_level);
          check_field("busy_res", want.busy_res, busy_res);
          check_field("done_res", want.done_res, done_res);
          check_field("rejected", want.rejected, rejected);
        end
        recv_stall = idle_len(recv_calm);
      end else begin
        recv_stall = recv_wait;
      end
      if (recv_stall != 0) begin
        out_ready <= 1'b0;
        recv_wait <= recv_stall - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    reset_sender_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset timing: idle tick, unused kind, a byte with loads refused while busy.
    // The ticks run past the end of the first long phase; the byte then
    // finishes under the short timing below.
    push_item(pwbs_pkg::KIND_TICK, 8'h00);
    push_item(KIND_UNUSED, 8'hFF);
    push_item(pwbs_pkg::KIND_BYTE, 8'hA5);
    push_item(pwbs_pkg::KIND_BYTE, 8'h5A);
    push_item(pwbs_pkg::KIND_MARK, 8'hFF);
    push_item(KIND_UNUSED, 8'h00);
    repeat (44) push_item(pwbs_pkg::KIND_TICK, 8'h00);

    // Short phases: all-ones, single-bit bytes and markers.
    set_timing(2, 1, 2, 1, 1);
    finish_sequence();
    push_item(pwbs_pkg::KIND_BYTE, 8'hFF);
    finish_sequence();
    push_item(pwbs_pkg::KIND_BYTE, 8'h80);
    push_item(pwbs_pkg::KIND_MARK, 8'h00);
    finish_sequence();
    push_item(pwbs_pkg::KIND_BYTE, 8'h01);
    finish_sequence();
    push_item(pwbs_pkg::KIND_MARK, 8'h3C);
    push_item(pwbs_pkg::KIND_BYTE, 8'hFF);
    push_item(pwbs_pkg::KIND_TICK, 8'hFF);
    push_item(KIND_UNUSED, 8'hC3);
    finish_sequence();
    push_item(pwbs_pkg::KIND_TICK, 8'h55);

    // Zero-length registers behave as one tick.
    set_timing(0, 2, 0, 0, 0);
    push_item(pwbs_pkg::KIND_BYTE, 8'h96);
    finish_sequence();
    push_item(pwbs_pkg::KIND_MARK, 8'h00);
    finish_sequence();

    // Longest phase: the tick counter runs up to its full range in the
    // first high phase, and the rest of the byte goes out at short timing.
    set_timing(255, 1, 1, 1, 1);
    push_item(pwbs_pkg::KIND_BYTE, 8'hFF);
    repeat (256) push_item(pwbs_pkg::KIND_TICK, 8'h00);
    set_timing(2, 1, 2, 1, 1);
    finish_sequence();

    // Random traffic under the shortest timing and under a random one.
    set_timing(1, 1, 1, 1, 1);
    run_random(40);
    set_timing($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6),
               $urandom_range(0, 6), $urandom_range(0, 6));
    run_random(40);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/pwbs_pkg.sv
design/pwbs_core.sv
design/pulse_width_bit_sender.sv
dv/pulse_width_bit_sender_tb.sv
